@@ rtl/header_length_frame_receiver_unit_macros.svh @@
// assertion macros used by the frame receiver parser module
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef HEADER_LENGTH_FRAME_RECEIVER_UNIT_MACROS_SVH
`define HEADER_LENGTH_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication
`define HLFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// next-cycle implication
`define HLFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

@@ rtl/hlfr_pkg.sv @@
// types and constants for the header/length frame receiver
// no dependencies
`timescale 1ns / 1ps

package hlfr_pkg;

  localparam int COUNT_W = 9;

  localparam logic [7:0] HEADER_BYTE_RESET    = 8'h5a;
  localparam logic [7:0] ACCEPT_COMMAND_RESET = 8'h45;

  localparam logic [7:0] REG_HEADER_BYTE    = 8'd0;
  localparam logic [7:0] REG_ACCEPT_COMMAND = 8'd1;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam int HEADER_BYTES   = 2;
  localparam int COMMAND_POS    = 2;
  localparam int LENGTH_POS     = 3;
  localparam int FRAME_OVERHEAD = 5;
  localparam int FIRST_DATA_POS = 4;
  localparam int DATA_OUTS      = 5;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] length_field;
    logic [7:0] data_4;
    logic [7:0] data_5;
    logic [7:0] data_6;
    logic [7:0] data_7;
    logic [7:0] data_8;
  } out_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] accept_command;
  } cfg_t;

endpackage

@@ rtl/hlfr_parser.sv @@
// frame parse state: byte count, captured frame bytes and hold flag
// depends on hlfr_pkg and header_length_frame_receiver_unit_macros.svh
`timescale 1ns / 1ps
`include "header_length_frame_receiver_unit_macros.svh"

module hlfr_parser import hlfr_pkg::*; #(
  parameter int CAPTURE_BYTES = 9
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  in_t  item,
  input  cfg_t cfg,
  output logic res_valid,
  output out_t res
);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [COUNT_W-1:0] cnt_work;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] frame_end;
  logic               frame_held, frame_held_next;
  logic [7:0]         frame_store [CAPTURE_BYTES];
  logic [7:0]         store_next  [CAPTURE_BYTES];
  logic [7:0]         tail        [DATA_OUTS];
  logic               wr;

  assign wr = step && (item.req_type == REQ_BYTE);

  // captured bytes with the current beat bypassed in
  always_comb begin
    for (int i = 0; i < CAPTURE_BYTES; i++) begin
      store_next[i] = (wr && byte_count == COUNT_W'(i)) ? item.rx_byte : frame_store[i];
    end
  end

  assign cnt_inc   = byte_count + 1'b1;
  assign frame_end = COUNT_W'(store_next[LENGTH_POS]) + COUNT_W'(FRAME_OVERHEAD);

  always_comb begin
    byte_count_next = byte_count;
    frame_held_next = frame_held;
    res_valid       = 1'b0;
    cnt_work        = cnt_inc;
    if (store_next[0] != cfg.header_byte) begin
      cnt_work = '0;
    end
    if (cnt_work == COUNT_W'(HEADER_BYTES) && store_next[1] != cfg.header_byte) begin
      cnt_work = '0;
    end
    if (cnt_work > COUNT_W'(LENGTH_POS) && cnt_work == frame_end) begin
      cnt_work = '0;
      if (store_next[COMMAND_POS] == cfg.accept_command && !frame_held) begin
        res_valid = wr;
      end
    end
    if (step) begin
      if (item.req_type == REQ_RELEASE) begin
        frame_held_next = 1'b0;
      end else begin
        byte_count_next = cnt_work;
        if (res_valid) begin
          frame_held_next = 1'b1;
        end
      end
    end
  end

  // positions beyond the capture depth read as zero
  for (genvar k = 0; k < DATA_OUTS; k++) begin : g_tail
    if (FIRST_DATA_POS + k < CAPTURE_BYTES) begin : g_kept
      assign tail[k] = store_next[FIRST_DATA_POS + k];
    end else begin : g_zero
      assign tail[k] = 8'h00;
    end
  end

  assign res.command      = store_next[COMMAND_POS];
  assign res.length_field = store_next[LENGTH_POS];
  assign res.data_4       = tail[0];
  assign res.data_5       = tail[1];
  assign res.data_6       = tail[2];
  assign res.data_7       = tail[3];
  assign res.data_8       = tail[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      frame_held <= 1'b0;
      for (int i = 0; i < CAPTURE_BYTES; i++) begin
        frame_store[i] <= 8'h00;
      end
    end else begin
      byte_count <= byte_count_next;
      frame_held <= frame_held_next;
      for (int i = 0; i < CAPTURE_BYTES; i++) begin
        frame_store[i] <= store_next[i];
      end
    end
  end

  `HLFR_ASSERT_NOW(a_res_from_byte, res_valid, step && item.req_type == REQ_BYTE)
  `HLFR_ASSERT_NOW(a_res_not_held, res_valid, !frame_held)
  `HLFR_ASSERT_NEXT(a_res_sets_hold, res_valid, frame_held && byte_count == '0)
  `HLFR_ASSERT_NOW(a_count_bound, 1'b1, byte_count < COUNT_W'(255 + FRAME_OVERHEAD))

endmodule

@@ rtl/header_length_frame_receiver_unit.sv @@
// header/length frame receiver top level: config registers, input and result registers
// depends on hlfr_pkg and hlfr_parser
`timescale 1ns / 1ps

// Takes one beat per clock on the item channel, either a received byte or a release
// of the held frame, while the result side is not stalled. An item is held in the
// input register and its result, if any, is loaded into the result register when the
// item is stepped through the count and compare path between the two registers; a
// stalled result holds the item in the input register. The result register keeps
// accepting while a stalled result is taken in the same cycle. Configuration writes
// complete at once (cfg_ready is tied high) and must be issued while idle; indexes
// other than header_byte (0) and accept_command (1) are ignored.
module header_length_frame_receiver_unit import hlfr_pkg::*; #(
  parameter int CAPTURE_BYTES = 9
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  in_t        item,
  output logic       result_valid,
  input  logic       result_ready,
  output out_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;
  logic ibuf_valid;
  in_t  ibuf;
  logic step;
  logic res_valid;
  out_t res;

  assign cfg_ready  = 1'b1;
  assign step       = ibuf_valid && (!result_valid || result_ready);
  assign item_ready = !ibuf_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte    <= HEADER_BYTE_RESET;
      cfg.accept_command <= ACCEPT_COMMAND_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER_BYTE:    cfg.header_byte    <= cfg_data;
        REG_ACCEPT_COMMAND: cfg.accept_command <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      ibuf_valid <= 1'b0;
    end else if (item_ready) begin
      ibuf_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      ibuf <= item;
    end
  end

  hlfr_parser #(
    .CAPTURE_BYTES(CAPTURE_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (ibuf),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= res_valid;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      result <= res;
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench for header_length_frame_receiver_unit: framed byte streams with releases,
// checked against a predicting scoreboard; depends on hlfr_pkg and the receiver rtl
`timescale 1ns / 1ps

module tb;
  import hlfr_pkg::*;

  localparam int CAPTURE_BYTES  = 9;
  localparam int RX_HOLDOFF     = 400;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 60;

  localparam logic [7:0] REG_UNUSED_LOW = 8'd2;
  localparam logic [7:0] REG_UNUSED_TOP = 8'hff;

  class frame_scoreboard;
    logic [7:0]         header_byte;
    logic [7:0]         accept_command;
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         frame_store [CAPTURE_BYTES];
    bit                 held;
    out_t               pending [$];
    int                 errors;
    int                 frames_expected;

    function new();
      header_byte     = HEADER_BYTE_RESET;
      accept_command  = ACCEPT_COMMAND_RESET;
      byte_count      = '0;
      held            = 1'b0;
      errors          = 0;
      frames_expected = 0;
      foreach (frame_store[i]) frame_store[i] = 8'h00;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] value);
      case (idx)
        REG_HEADER_BYTE: header_byte = value;
        REG_ACCEPT_COMMAND: accept_command = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] stored_at(int pos);
      if (pos < CAPTURE_BYTES) return frame_store[pos];
      return 8'h00;
    endfunction

    function void note_item(in_t it);
      out_t frame;
      if (it.req_type == REQ_RELEASE) begin
        held = 1'b0;
        return;
      end
      if (byte_count < COUNT_W'(CAPTURE_BYTES)) frame_store[byte_count] = it.rx_byte;
      byte_count = byte_count + 1'b1;
      if (frame_store[0] != header_byte) byte_count = '0;
      if (byte_count == COUNT_W'(HEADER_BYTES) && frame_store[1] != header_byte)
        byte_count = '0;
      if (byte_count > COUNT_W'(LENGTH_POS)) begin
        if (byte_count == ({1'b0, frame_store[LENGTH_POS]} + COUNT_W'(FRAME_OVERHEAD))) begin
          byte_count = '0;
          if (frame_store[COMMAND_POS] == accept_command && !held) begin
            held               = 1'b1;
            frame.command      = frame_store[COMMAND_POS];
            frame.length_field = frame_store[LENGTH_POS];
            frame.data_4       = stored_at(FIRST_DATA_POS);
            frame.data_5       = stored_at(FIRST_DATA_POS + 1);
            frame.data_6       = stored_at(FIRST_DATA_POS + 2);
            frame.data_7       = stored_at(FIRST_DATA_POS + 3);
            frame.data_8       = stored_at(FIRST_DATA_POS + 4);
            pending.push_back(frame);
            frames_expected++;
          end
        end
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with none expected, expected nothing actual %h",
                   $time, got);
        return;
      end
      want = pending.pop_front();
      check_field("command", want.command, got.command);
      check_field("length_field", want.length_field, got.length_field);
      check_field("data_4", want.data_4, got.data_4);
      check_field("data_5", want.data_5, got.data_5);
      check_field("data_6", want.data_6, got.data_6);
      check_field("data_7", want.data_7, got.data_7);
      check_field("data_8", want.data_8, got.data_8);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       item_valid;
  logic       item_ready;
  in_t        item;
  logic       result_valid;
  logic       result_ready;
  out_t       result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;

  frame_scoreboard board = new();
  int items_sent    = 0;
  int quiet_cycles  = 0;
  bit idle_on       = 1'b1;
  bit stall_request = 1'b0;

  header_length_frame_receiver_unit #(
    .CAPTURE_BYTES(CAPTURE_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
  end

  // result side
  initial begin
    forever begin
      @(negedge clk);
      if (stall_request) begin
        result_ready <= 1'b0;
        repeat (RX_HOLDOFF) @(negedge clk);
        stall_request = 1'b0;
      end
      result_ready <= !(idle_on && $urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) board.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(in_t it);
    if (idle_on && $urandom_range(99) < 32) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    in_t it;
    it.req_type = REQ_BYTE;
    it.rx_byte  = b;
    send_item(it);
  endtask

  task automatic send_release();
    in_t it;
    it.req_type = REQ_RELEASE;
    it.rx_byte  = 8'($urandom_range(255));
    send_item(it);
  endtask

  task automatic send_bytes(logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_frame(logic [7:0] cmd, int len);
    send_byte(board.header_byte);
    send_byte(board.header_byte);
    send_byte(cmd);
    send_byte(8'(len));
    repeat (len + 1) send_byte(8'($urandom_range(255)));
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(int n);
    int         start;
    int         pick;
    int         r;
    int         len;
    logic [7:0] cmd;
    start = items_sent;
    while (items_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 66) begin
        cmd = ($urandom_range(99) < 80) ? board.accept_command : 8'($urandom_range(255));
        r   = $urandom_range(99);
        if (r < 88) len = $urandom_range(0, 6);
        else if (r < 99) len = $urandom_range(7, 20);
        else len = $urandom_range(0, 255);
        send_frame(cmd, len);
        if ($urandom_range(1)) send_release();
      end else if (pick < 80) begin
        send_release();
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        // header followed by a cut-off or corrupted frame
        send_byte(board.header_byte);
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [7:0] first_frame [$] = '{HEADER_BYTE_RESET, HEADER_BYTE_RESET,
                                    ACCEPT_COMMAND_RESET, 8'h00, 8'h3c};
    logic [7:0] held_frame  [$] = '{HEADER_BYTE_RESET, HEADER_BYTE_RESET,
                                    ACCEPT_COMMAND_RESET, 8'h00, 8'hc3};
    logic [7:0] long_frame  [$] = '{HEADER_BYTE_RESET, HEADER_BYTE_RESET,
                                    ACCEPT_COMMAND_RESET, 8'h05, 8'hff, 8'hff,
                                    8'hff, 8'hff, 8'hff, 8'hff};
    logic [7:0] bad_header  [$] = '{8'h00, HEADER_BYTE_RESET, 8'h12};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings
    send_bytes(first_frame);
    send_bytes(held_frame);
    send_release();
    send_release();
    send_bytes(long_frame);
    send_bytes(bad_header);

    // no idling on either side
    idle_on = 1'b0;
    run_traffic(80);
    drain();
    idle_on = 1'b1;

    write_reg(REG_HEADER_BYTE, 8'h00);
    write_reg(REG_ACCEPT_COMMAND, 8'h00);
    write_reg(REG_UNUSED_LOW, 8'ha5);
    run_traffic(40);
    stall_request = 1'b1;
    run_traffic(60);
    drain();

    write_reg(REG_HEADER_BYTE, 8'hff);
    write_reg(REG_ACCEPT_COMMAND, 8'hff);
    write_reg(REG_UNUSED_TOP, 8'h5a);
    run_traffic(50);
    drain();
    send_frame(board.accept_command, 255);
    send_release();
    run_traffic(50);
    drain();

    write_reg(REG_HEADER_BYTE, 8'($urandom_range(255)));
    write_reg(REG_ACCEPT_COMMAND, 8'($urandom_range(255)));
    run_traffic(70);
    drain();

    write_reg(REG_ACCEPT_COMMAND, 8'($urandom_range(255)));
    write_reg(REG_HEADER_BYTE, 8'($urandom_range(255)));
    run_traffic(70);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/hlfr_pkg.sv
rtl/hlfr_parser.sv
rtl/header_length_frame_receiver_unit.sv
tb/tb.sv
